FILE: rtl/alen_pkg.sv
// Shared types, codes and constants for the array list engine.
package alen_pkg;

   localparam int CAPACITY_DEF = 64;
   localparam int KEY_W        = 32;
   localparam int COUNT_W      = 7;
   localparam int OP_W         = 3;

   // Operation codes
   localparam logic [OP_W-1:0] OP_CLEAR  = 3'd0;
   localparam logic [OP_W-1:0] OP_FRONT  = 3'd1;
   localparam logic [OP_W-1:0] OP_END    = 3'd2;
   localparam logic [OP_W-1:0] OP_ORDER  = 3'd3;
   localparam logic [OP_W-1:0] OP_REMOVE = 3'd4;
   localparam logic [OP_W-1:0] OP_SEARCH = 3'd5;

   typedef struct packed {
      logic [OP_W-1:0]         op;
      logic signed [KEY_W-1:0] key;
   } req_type;

   typedef struct packed {
      logic               ok;
      logic [COUNT_W-1:0] count;
   } rsp_type;

   typedef enum logic [2:0] {
      PTR_HOLD, PTR_ZERO, PTR_INC, PTR_DEC, PTR_LAST, PTR_MID
   } ptr_cmd_type;

   typedef enum logic [1:0] {USED_HOLD, USED_CLEAR, USED_INC, USED_DEC} used_cmd_type;
   typedef enum logic [1:0] {POS_HOLD, POS_ZERO, POS_USED, POS_PTR} pos_cmd_type;
   typedef enum logic [1:0] {BND_HOLD, BND_INIT, BND_LO, BND_HI} bnd_cmd_type;
   typedef enum logic [1:0] {WR_NONE, WR_UP, WR_DOWN, WR_KEY} wr_cmd_type;

   typedef struct packed {
      logic         load;
      ptr_cmd_type  ptr;
      used_cmd_type used;
      pos_cmd_type  pos;
      bnd_cmd_type  bnd;
      wr_cmd_type   wr;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic at_end;
      logic last;
      logic ent_lt;
      logic ent_eq;
      logic at_pos;
      logic room_above;
      logic bnd_open;
   } stat_type;

endpackage

FILE: rtl/alen_ram.sv
// Generic single-write, single-read RAM with registered read data.
module alen_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/alen_dp.sv
// Datapath: entry store, count, scan pointer, insert position and search bounds.
module alen_dp #(
   parameter int CAPACITY = alen_pkg::CAPACITY_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  alen_pkg::cmd_type                cmd,
   input  logic signed [alen_pkg::KEY_W-1:0] req_key,
   output alen_pkg::stat_type               stat,
   output logic [alen_pkg::COUNT_W-1:0]     count
);

   localparam int AW     = $clog2(CAPACITY);
   localparam int UW     = $clog2(CAPACITY + 1);
   localparam int KeyW   = alen_pkg::KEY_W;
   localparam int CountW = alen_pkg::COUNT_W;

   logic [UW-1:0]          used_ff, used_in;
   logic [UW-1:0]          ptr_ff, ptr_in;
   logic [UW-1:0]          pos_ff, pos_in;
   logic [UW-1:0]          lo_ff, lo_in;
   logic [UW-1:0]          bound_ff, bound_in;
   logic signed [KeyW-1:0] key_ff, key_in;
   logic [UW-1:0]          span;
   logic [UW-1:0]          mid;
   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   logic [KeyW-1:0]        wr_data;
   logic [KeyW-1:0]        rd_data;

   // Midpoint of the open range [lo, bound), valid while lo < bound
   assign span = bound_ff - lo_ff - UW'(1);
   assign mid  = lo_ff + (span >> 1);

   always_comb begin
      unique case (cmd.ptr)
         alen_pkg::PTR_HOLD: ptr_in = ptr_ff;
         alen_pkg::PTR_ZERO: ptr_in = '0;
         alen_pkg::PTR_INC:  ptr_in = ptr_ff + UW'(1);
         alen_pkg::PTR_DEC:  ptr_in = ptr_ff - UW'(1);
         alen_pkg::PTR_LAST: ptr_in = used_ff - UW'(1);
         alen_pkg::PTR_MID:  ptr_in = mid;
         default:            ptr_in = ptr_ff;
      endcase

      unique case (cmd.used)
         alen_pkg::USED_HOLD:  used_in = used_ff;
         alen_pkg::USED_CLEAR: used_in = '0;
         alen_pkg::USED_INC:   used_in = used_ff + UW'(1);
         alen_pkg::USED_DEC:   used_in = used_ff - UW'(1);
      endcase

      unique case (cmd.pos)
         alen_pkg::POS_HOLD: pos_in = pos_ff;
         alen_pkg::POS_ZERO: pos_in = '0;
         alen_pkg::POS_USED: pos_in = used_ff;
         alen_pkg::POS_PTR:  pos_in = ptr_ff;
      endcase

      lo_in    = lo_ff;
      bound_in = bound_ff;
      unique case (cmd.bnd)
         alen_pkg::BND_HOLD: ;
         alen_pkg::BND_INIT: begin
            lo_in    = '0;
            bound_in = used_ff;
         end
         alen_pkg::BND_LO:   lo_in = ptr_ff + UW'(1);
         alen_pkg::BND_HI:   bound_in = ptr_ff;
      endcase

      key_in = cmd.load ? req_key : key_ff;

      // Shifts move the entry read last cycle one slot up or down
      wr_en   = 1'b1;
      wr_data = rd_data;
      unique case (cmd.wr)
         alen_pkg::WR_NONE: begin
            wr_en   = 1'b0;
            wr_addr = ptr_ff[AW-1:0];
         end
         alen_pkg::WR_UP:   wr_addr = AW'(ptr_ff + UW'(1));
         alen_pkg::WR_DOWN: wr_addr = AW'(ptr_ff - UW'(1));
         alen_pkg::WR_KEY: begin
            wr_addr = pos_ff[AW-1:0];
            wr_data = key_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else begin
         used_ff <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff   <= ptr_in;
      pos_ff   <= pos_in;
      lo_ff    <= lo_in;
      bound_ff <= bound_in;
      key_ff   <= key_in;
   end

   // Read follows the next pointer, so data for ptr_ff is ready each cycle
   alen_ram #(
      .WIDTH (KeyW),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (ptr_in[AW-1:0]),
      .rd_data (rd_data)
   );

   assign stat.full       = (used_ff == UW'(CAPACITY));
   assign stat.at_end     = (ptr_ff >= used_ff);
   assign stat.last       = (({1'b0, ptr_ff} + (UW+1)'(1)) >= {1'b0, used_ff});
   assign stat.ent_lt     = ($signed(rd_data) < key_ff);
   assign stat.ent_eq     = (rd_data == key_ff);
   assign stat.at_pos     = (ptr_ff == pos_ff);
   assign stat.room_above = (used_ff > pos_ff);
   assign stat.bnd_open   = (lo_ff < bound_ff);

   assign count = CountW'(used_ff);

endmodule

FILE: rtl/alen_ctrl.sv
// Controller state machine: decodes the operation and sequences the datapath.
module alen_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [alen_pkg::OP_W-1:0]    req_op,
   input  alen_pkg::stat_type           stat,
   output alen_pkg::cmd_type            cmd,
   output logic                         busy,
   output logic                         rsp_valid,
   output logic                         rsp_ok
);

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_DECODE = 9'b000000010,
      S_SCAN   = 9'b000000100,
      S_SHPREP = 9'b000001000,
      S_SHUP   = 9'b000010000,
      S_PUT    = 9'b000100000,
      S_SHDN   = 9'b001000000,
      S_BS_CHK = 9'b010000000,
      S_BS_CMP = 9'b100000000
   } state_type;

   state_type                     state_ff, state_in;
   logic [alen_pkg::OP_W-1:0]     op_ff, op_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_ok_ff, rsp_ok_in;
   logic                          is_insert;

   assign is_insert = (op_ff == alen_pkg::OP_FRONT) || (op_ff == alen_pkg::OP_END) ||
                      (op_ff == alen_pkg::OP_ORDER);

   always_comb begin
      cmd.load     = 1'b0;
      cmd.ptr      = alen_pkg::PTR_HOLD;
      cmd.used     = alen_pkg::USED_HOLD;
      cmd.pos      = alen_pkg::POS_HOLD;
      cmd.bnd      = alen_pkg::BND_HOLD;
      cmd.wr       = alen_pkg::WR_NONE;
      state_in     = state_ff;
      op_in        = op_ff;
      rsp_valid_in = 1'b0;
      rsp_ok_in    = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               op_in    = req_op;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (is_insert && stat.full) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               unique case (op_ff) inside
                  alen_pkg::OP_CLEAR: begin
                     cmd.used     = alen_pkg::USED_CLEAR;
                     rsp_valid_in = 1'b1;
                     rsp_ok_in    = 1'b1;
                     state_in     = S_IDLE;
                  end
                  alen_pkg::OP_FRONT: begin
                     cmd.pos  = alen_pkg::POS_ZERO;
                     state_in = S_SHPREP;
                  end
                  alen_pkg::OP_END: begin
                     cmd.pos  = alen_pkg::POS_USED;
                     state_in = S_SHPREP;
                  end
                  alen_pkg::OP_ORDER, alen_pkg::OP_REMOVE: begin
                     cmd.ptr  = alen_pkg::PTR_ZERO;
                     state_in = S_SCAN;
                  end
                  alen_pkg::OP_SEARCH: begin
                     cmd.bnd  = alen_pkg::BND_INIT;
                     state_in = S_BS_CHK;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     state_in     = S_IDLE;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (op_ff == alen_pkg::OP_ORDER) begin
               // Stop at the first entry not less than the key
               if (stat.at_end || !stat.ent_lt) begin
                  cmd.pos  = alen_pkg::POS_PTR;
                  state_in = S_SHPREP;
               end else begin
                  cmd.ptr = alen_pkg::PTR_INC;
               end
            end else if (stat.at_end) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else if (stat.ent_eq) begin
               if (stat.last) begin
                  cmd.used     = alen_pkg::USED_DEC;
                  rsp_valid_in = 1'b1;
                  rsp_ok_in    = 1'b1;
                  state_in     = S_IDLE;
               end else begin
                  cmd.ptr  = alen_pkg::PTR_INC;
                  state_in = S_SHDN;
               end
            end else begin
               cmd.ptr = alen_pkg::PTR_INC;
            end
         end
         S_SHPREP: begin
            if (stat.room_above) begin
               cmd.ptr  = alen_pkg::PTR_LAST;
               state_in = S_SHUP;
            end else begin
               state_in = S_PUT;
            end
         end
         S_SHUP: begin
            cmd.wr = alen_pkg::WR_UP;
            if (stat.at_pos) begin
               state_in = S_PUT;
            end else begin
               cmd.ptr = alen_pkg::PTR_DEC;
            end
         end
         S_PUT: begin
            cmd.wr       = alen_pkg::WR_KEY;
            cmd.used     = alen_pkg::USED_INC;
            rsp_valid_in = 1'b1;
            rsp_ok_in    = 1'b1;
            state_in     = S_IDLE;
         end
         S_SHDN: begin
            cmd.wr = alen_pkg::WR_DOWN;
            if (stat.last) begin
               cmd.used     = alen_pkg::USED_DEC;
               rsp_valid_in = 1'b1;
               rsp_ok_in    = 1'b1;
               state_in     = S_IDLE;
            end else begin
               cmd.ptr = alen_pkg::PTR_INC;
            end
         end
         S_BS_CHK: begin
            if (stat.bnd_open) begin
               cmd.ptr  = alen_pkg::PTR_MID;
               state_in = S_BS_CMP;
            end else begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_BS_CMP: begin
            if (stat.ent_eq) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = 1'b1;
               state_in     = S_IDLE;
            end else begin
               cmd.bnd  = stat.ent_lt ? alen_pkg::BND_LO : alen_pkg::BND_HI;
               state_in = S_BS_CHK;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      rsp_ok_ff <= rsp_ok_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_ok    = rsp_ok_ff;

endmodule

FILE: rtl/array_list_engine_unit.sv
// Top level of the array list engine: controller plus datapath.
//
// A bounded list of up to CAPACITY signed 32-bit keys kept in one RAM with
// a single write port and a registered read port; every step below touches
// at most one entry per cycle through that port. A request transfers on a
// clock edge where start is high and busy is low; busy then stays high
// until the result is produced. The result is shown on rsp_data for exactly
// one cycle with rsp_valid high and cannot be stalled, so capture it then;
// a new request may transfer in that same cycle. With n the count before
// the operation and k the index where a scan stops: clear, unused codes
// and a failed insert on a full list answer from decode; insert at end
// writes the key at once; insert at front first shifts all n entries up;
// ordered insert scans to k, then shifts the n - k entries from k up;
// remove scans to the match at k and shifts each later entry down; search
// probes the midpoint of the remaining range until a match or an empty
// range. The worst case, an insert that shifts a nearly full list, is
// bounded by the one-entry-per-cycle shift through the memory port. Keys
// are compared as signed values; search assumes ascending contents. The
// count field reports the count after the operation, truncated to 7 bits.
module array_list_engine_unit #(
   parameter int CAPACITY = alen_pkg::CAPACITY_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  alen_pkg::req_type req_data,
   output logic              rsp_valid,
   output alen_pkg::rsp_type rsp_data
);

   alen_pkg::cmd_type                 cmd;
   alen_pkg::stat_type                stat;
   logic                              rsp_ok;
   logic [alen_pkg::COUNT_W-1:0]      count;

   // Sequence each operation; hold busy until the result strobe is issued
   alen_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_op    (req_data.op),
      .stat      (stat),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_ok    (rsp_ok)
   );

   // Store entries, advance the pointer, shift and compare under command
   alen_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .req_key (req_data.key),
      .stat    (stat),
      .count   (count)
   );

   // Count is already updated when the strobe rises and holds until the next transfer
   assign rsp_data.ok    = rsp_ok;
   assign rsp_data.count = count;

endmodule
